/* hw/rtl/glyph_bitmap_pixel_expander_macros.svh */
// assertion macros for the glyph bitmap pixel expander
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_MACROS_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_MACROS_SVH
`ifndef SYNTHESIS
`define GBPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbpe assertion failed");
`define GBPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbpe assertion failed");
`else
`define GBPE_ASSERT_NOW(lbl, ante, cons)
`define GBPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/gbpe_pkg.sv */
// shared types, constants and helpers for the glyph bitmap pixel expander
`default_nettype none
package gbpe_pkg;

  localparam int PANEL_WIDTH_DEF  = 800;
  localparam int PANEL_HEIGHT_DEF = 480;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 6;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 10;
  localparam int TAKEN_W    = 7;
  localparam int PIX_IDX_W  = 19;
  localparam int PROD_W     = 22;

  localparam logic [SIZE_W-1:0]  FONT_SIZE_RST  = 6'd16;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 16'h0000;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_SIZE    = 3'd0,
    CFG_OVERLAY_MODE = 3'd1,
    CFG_TEXT_COLOR   = 3'd2,
    CFG_BACK_COLOR   = 3'd3,
    CFG_LANDSCAPE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  font_size;
    logic               overlay_mode;
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] back_color;
    logic               landscape;
  } cfg_t;

  // one font byte as the back end sees it
  typedef struct packed {
    logic [7:0]         bits;
    logic [7:0]         mask;   // bit k set: pixel k of the column run is written
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } job_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [TAKEN_W-1:0] glyph_total(input logic [SIZE_W-1:0] size);
    logic [TAKEN_W-1:0] t;
    unique case (size)
      6'd12:   t = 7'd12;
      6'd16:   t = 7'd16;
      6'd24:   t = 7'd36;
      6'd32:   t = 7'd64;
      default: t = 7'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gbpe_front.sv */
// front end: tracks the glyph cursor and turns each font byte into a pixel job
`default_nettype none
module gbpe_front
  import gbpe_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               accept,
  input  wire logic [7:0]         font_byte,
  input  wire logic               glyph_start,
  input  wire logic [COORD_W-1:0] start_x,
  input  wire logic [COORD_W-1:0] start_y,
  output job_t                    job,
  output logic                    job_push
);

  localparam logic [COORD_W:0] W_LIM = (COORD_W+1)'(PANEL_WIDTH);
  localparam logic [COORD_W:0] H_LIM = (COORD_W+1)'(PANEL_HEIGHT);

  logic [COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [COORD_W-1:0] column_top_r, column_top_nxt;
  logic [TAKEN_W-1:0] bytes_taken_r, bytes_taken_nxt;
  logic               glyph_done_r, glyph_done_nxt;

  logic [COORD_W-1:0] eff_x, eff_y, eff_top;
  logic [TAKEN_W-1:0] eff_taken, total, taken_inc;
  logic               eff_done, active;
  logic [COORD_W:0]   yk, ynk, difk, brk_yn, x_inc;
  logic               seen, brk_bot, brk_col;
  logic [7:0]         emit;

  function automatic logic on_panel(input logic [COORD_W-1:0] x, input logic [COORD_W:0] y,
                                    input logic land);
    logic r;
    if (land) begin
      r = ({1'b0, x} < W_LIM) && (y < H_LIM);
    end else begin
      r = ({1'b0, x} < H_LIM) && (y < W_LIM);
    end
    return r;
  endfunction

  assign eff_x     = glyph_start ? start_x : cursor_x_r;
  assign eff_y     = glyph_start ? start_y : cursor_y_r;
  assign eff_top   = glyph_start ? start_y : column_top_r;
  assign eff_taken = glyph_start ? '0 : bytes_taken_r;
  assign eff_done  = glyph_start ? 1'b0 : glyph_done_r;
  assign total     = glyph_total(cfg.font_size);
  assign active    = !eff_done && (total != '0) && (eff_taken < total);
  assign taken_inc = eff_taken + 7'd1;
  assign x_inc     = {1'b0, eff_x} + 11'd1;

  // walk the eight bits; the column run stops at the bottom edge or after font_size rows
  always_comb begin
    seen    = 1'b0;
    brk_bot = 1'b0;
    brk_col = 1'b0;
    brk_yn  = '0;
    emit    = '0;
    yk      = '0;
    ynk     = '0;
    difk    = '0;
    for (int k = 0; k < 8; k++) begin
      yk   = {1'b0, eff_y} + 11'(k);
      ynk  = yk + 11'd1;
      difk = ynk - {1'b0, eff_top};
      if (!seen) begin
        if ((font_byte[7-k] || !cfg.overlay_mode) && on_panel(eff_x, yk, cfg.landscape)) begin
          emit[k] = 1'b1;
        end
        if (ynk >= H_LIM) begin
          seen    = 1'b1;
          brk_bot = 1'b1;
          brk_yn  = ynk;
        end else if (difk >= {5'b0, cfg.font_size}) begin
          seen    = 1'b1;
          brk_col = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cursor_x_nxt    = eff_x;
    cursor_y_nxt    = eff_y;
    column_top_nxt  = eff_top;
    bytes_taken_nxt = eff_taken;
    glyph_done_nxt  = 1'b1;
    if (active) begin
      bytes_taken_nxt = taken_inc;
      glyph_done_nxt  = 1'b0;
      priority if (brk_bot) begin
        cursor_y_nxt   = brk_yn[COORD_W-1:0];
        glyph_done_nxt = 1'b1;
      end else if (brk_col) begin
        cursor_y_nxt = eff_top;
        cursor_x_nxt = x_inc[COORD_W-1:0];
        if (x_inc >= W_LIM) begin
          glyph_done_nxt = 1'b1;
        end
      end else begin
        cursor_y_nxt = eff_y + 10'd8;
      end
      if (taken_inc >= total) begin
        glyph_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      column_top_r  <= '0;
      bytes_taken_r <= '0;
      glyph_done_r  <= 1'b1;
    end else if (accept) begin
      cursor_x_r    <= cursor_x_nxt;
      cursor_y_r    <= cursor_y_nxt;
      column_top_r  <= column_top_nxt;
      bytes_taken_r <= bytes_taken_nxt;
      glyph_done_r  <= glyph_done_nxt;
    end
  end

  assign job.bits = font_byte;
  assign job.mask = emit;
  assign job.x    = eff_x;
  assign job.y    = eff_y;
  assign job_push = accept && active && (emit != '0);

endmodule
`default_nettype wire

/* hw/rtl/gbpe_queue.sv */
// short job queue between front and back end
`default_nettype none
module gbpe_queue
  import gbpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      valid,
  output logic      full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t               mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign valid = count_r != '0;
  assign full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gbpe_back.sv */
// back end: one pixel write a cycle from the current job into the output register, unless stalled
`default_nettype none
module gbpe_back
  import gbpe_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire job_t                 q_head,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  output back_stat_t                stat,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [PIX_IDX_W-1:0]      out_pixel_index,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_last_of_byte
);

  localparam logic [COORD_W:0] H_M1 = (COORD_W+1)'(PANEL_HEIGHT - 1);
  localparam logic [PROD_W-1:0] W_P = PROD_W'(PANEL_WIDTH);

  logic                 busy_r, busy_nxt;
  logic [7:0]           bits_r, mask_r, mask_nxt;
  logic [COORD_W-1:0]   x_r, y_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_IDX_W-1:0] idx_r;
  logic [COLOR_W-1:0]   color_r;
  logic                 last_r;

  logic [2:0]           sel;
  logic [7:0]           rest;
  logic                 last, adv, load;
  logic [COORD_W:0]     y_pix, row, col;
  logic [PROD_W-1:0]    idx_full;
  logic [COLOR_W-1:0]   color;

  // lowest pending pixel first, which is the most significant remaining font bit
  always_comb begin
    sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel = 3'(k);
      end
    end
  end

  assign rest  = mask_r & ~(8'd1 << sel);
  assign last  = rest == '0;
  assign adv   = busy_r && (!out_valid_r || out_pop);
  assign load  = q_valid && (!busy_r || (adv && last));
  assign q_pop = load;

  assign y_pix    = {1'b0, y_r} + 11'(sel);
  assign row      = cfg.landscape ? y_pix : (H_M1 - {1'b0, x_r});
  assign col      = cfg.landscape ? {1'b0, x_r} : y_pix;
  assign idx_full = W_P * PROD_W'(row) + PROD_W'(col);
  assign color    = bits_r[3'd7 - sel] ? cfg.text_color : cfg.back_color;

  always_comb begin
    busy_nxt = busy_r;
    mask_nxt = mask_r;
    if (adv) begin
      mask_nxt = rest;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      mask_nxt = q_head.mask;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (load) begin
      bits_r <= q_head.bits;
      x_r    <= q_head.x;
      y_r    <= q_head.y;
    end
    if (adv) begin
      idx_r   <= idx_full[PIX_IDX_W-1:0];
      color_r <= color;
      last_r  <= last;
    end
  end

  assign stat.busy        = busy_r;
  assign out_empty        = !out_valid_r;
  assign out_pixel_index  = idx_r;
  assign out_pixel_color  = color_r;
  assign out_last_of_byte = last_r;

endmodule
`default_nettype wire

/* hw/rtl/glyph_bitmap_pixel_expander.sv */
// Glyph bitmap pixel expander, top level.
// Input channel: push a font byte with in_push while in_full is low. Bytes run
// column-major, MSB first; in_glyph_start on the first byte of a glyph loads
// in_start_x / in_start_y as the glyph's top-left corner.
// Result channel: while out_empty is low a framebuffer write (pixel index and
// RGB565 color) waits on the out_ ports; out_pop takes it. out_last_of_byte
// marks the final write of one font byte. A byte makes 0 to 8 writes.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no byte is in flight.
// Flow: an accepted byte is turned into a pixel job; the job queue holds two
// bytes. The back end issues one pixel write per cycle while the receiver
// keeps popping; a byte's writes go from the job queue through the back end's
// job registers into the output register on the out_ ports.
// When the receiver stalls, the output register holds, the back end and then
// the job queue fill, and in_full rises. Reset clears the queue and output,
// leaves no glyph active and loads the default configuration.
`default_nettype none
`include "glyph_bitmap_pixel_expander_macros.svh"
module glyph_bitmap_pixel_expander
  import gbpe_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [7:0]            in_font_byte,
  input  wire logic                  in_glyph_start,
  input  wire logic [COORD_W-1:0]    in_start_x,
  input  wire logic [COORD_W-1:0]    in_start_y,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [PIX_IDX_W-1:0]       out_pixel_index,
  output logic [COLOR_W-1:0]         out_pixel_color,
  output logic                       out_last_of_byte,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PIX_LIMIT = PANEL_WIDTH * PANEL_HEIGHT;

  cfg_t       cfg_r;
  logic       in_accept;
  job_t       f_job, q_head;
  logic       f_push, q_valid, q_full, q_pop;
  back_stat_t b_stat;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_size    <= FONT_SIZE_RST;
      cfg_r.overlay_mode <= 1'b0;
      cfg_r.text_color   <= TEXT_COLOR_RST;
      cfg_r.back_color   <= BACK_COLOR_RST;
      cfg_r.landscape    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FONT_SIZE:    cfg_r.font_size    <= cfg_data[SIZE_W-1:0];
        CFG_OVERLAY_MODE: cfg_r.overlay_mode <= cfg_data[0];
        CFG_TEXT_COLOR:   cfg_r.text_color   <= cfg_data[COLOR_W-1:0];
        CFG_BACK_COLOR:   cfg_r.back_color   <= cfg_data[COLOR_W-1:0];
        CFG_LANDSCAPE:    cfg_r.landscape    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gbpe_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .font_byte   (in_font_byte),
    .glyph_start (in_glyph_start),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .job         (f_job),
    .job_push    (f_push)
  );

  gbpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_job (f_job),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid),
    .full     (q_full)
  );

  gbpe_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_head           (q_head),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .stat             (b_stat),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_color  (out_pixel_color),
    .out_last_of_byte (out_last_of_byte)
  );

  // a job is only written into the queue when there is room
  `GBPE_ASSERT_NOW(a_push_room, f_push, !q_full)
  // with nothing in flight the result side drains and stays empty
  `GBPE_ASSERT_NEXT(a_idle_empty, !b_stat.busy && !q_valid && (out_empty || out_pop), out_empty)
  // every issued write lands inside the framebuffer
  `GBPE_ASSERT_NOW(a_index_range, !out_empty, 32'(out_pixel_index) < PIX_LIMIT)
  // the queue only hands a job over when it has one
  `GBPE_ASSERT_NOW(a_pop_valid, q_pop, q_valid)

endmodule
`default_nettype wire

/* tb/glyph_bitmap_pixel_expander_tb.sv */
// testbench for the glyph bitmap pixel expander: font bytes in, pixel writes checked in order
`timescale 1ns / 100ps
module glyph_bitmap_pixel_expander_tb
  import gbpe_pkg::*;
();

  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pix_idx;
    logic [COLOR_W-1:0]   pix_color;
    logic                 last_of_byte;
  } pixel_write_t;

  // glyph raster predictor plus the queue of pixel writes still owed by the block
  class pixel_write_board;
    cfg_t               cfg;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] col_top;
    logic [TAKEN_W-1:0] taken;
    logic               glyph_done;
    pixel_write_t       expected_writes[$];
    int                 mismatches;

    function new();
      cfg.font_size    = 6'd16;
      cfg.overlay_mode = 1'b0;
      cfg.text_color   = 16'h0000;
      cfg.back_color   = 16'hFFFF;
      cfg.landscape    = 1'b1;
      cur_x            = '0;
      cur_y            = '0;
      col_top          = '0;
      taken            = '0;
      glyph_done       = 1'b1;
      mismatches       = 0;
    endfunction

    function int unsigned glyph_bytes(input logic [SIZE_W-1:0] s);
      case (s)
        6'd12, 6'd16, 6'd24, 6'd32: return ((s + 7) / 8) * (s / 2);
        default: return 0;
      endcase
    endfunction

    function void apply_register(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
      case (r)
        CFG_FONT_SIZE:    cfg.font_size    = d[SIZE_W-1:0];
        CFG_OVERLAY_MODE: cfg.overlay_mode = d[0];
        CFG_TEXT_COLOR:   cfg.text_color   = d;
        CFG_BACK_COLOR:   cfg.back_color   = d;
        CFG_LANDSCAPE:    cfg.landscape    = d[0];
        default: ;
      endcase
    endfunction

    function bit on_panel(input int unsigned x, input int unsigned y);
      if (cfg.landscape) return x < PANEL_WIDTH_DEF && y < PANEL_HEIGHT_DEF;
      return x < PANEL_HEIGHT_DEF && y < PANEL_WIDTH_DEF;
    endfunction

    function logic [PIX_IDX_W-1:0] pixel_offset(input int unsigned x, input int unsigned y);
      int unsigned off;
      if (cfg.landscape) off = PANEL_WIDTH_DEF * y + x;
      else off = PANEL_WIDTH_DEF * (PANEL_HEIGHT_DEF - x - 1) + y;
      return PIX_IDX_W'(off);
    endfunction

    // returns 1 when the byte was rasterized as part of an active glyph
    function bit note_byte(input logic [7:0] fb, input logic st,
                           input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
      int unsigned  x;
      int unsigned  y;
      int unsigned  total;
      logic [7:0]   bits;
      bit           set;
      bit           any;
      pixel_write_t w;
      if (st) begin
        cur_x      = sx;
        cur_y      = sy;
        col_top    = sy;
        taken      = '0;
        glyph_done = 1'b0;
      end
      if (glyph_done) return 0;
      total = glyph_bytes(cfg.font_size);
      if (total == 0 || taken >= total) begin
        glyph_done = 1'b1;
        return 0;
      end
      x    = cur_x;
      y    = cur_y;
      bits = fb;
      any  = 0;
      for (int k = 0; k < 8; k++) begin
        set = bits[7];
        if ((set || !cfg.overlay_mode) && on_panel(x, y)) begin
          w.pix_idx      = pixel_offset(x, y);
          w.pix_color    = set ? cfg.text_color : cfg.back_color;
          w.last_of_byte = 1'b0;
          expected_writes.push_back(w);
          any = 1;
        end
        bits = bits << 1;
        y++;
        if (y >= PANEL_HEIGHT_DEF) begin
          glyph_done = 1'b1;
          break;
        end
        // column is full: rest of the byte is dropped
        if (y - col_top >= cfg.font_size) begin
          y = col_top;
          x++;
          if (x >= PANEL_WIDTH_DEF) glyph_done = 1'b1;
          break;
        end
      end
      taken = taken + 1'b1;
      if (taken >= total) glyph_done = 1'b1;
      cur_x = COORD_W'(x);
      cur_y = COORD_W'(y);
      if (any) begin
        w = expected_writes.pop_back();
        w.last_of_byte = 1'b1;
        expected_writes.push_back(w);
      end
      return 1;
    endfunction

    function void check_write(input logic [PIX_IDX_W-1:0] idx, input logic [COLOR_W-1:0] color,
                              input logic last);
      pixel_write_t w;
      if (expected_writes.size() == 0) begin
        $error("unexpected pixel write: pixel_index %0d pixel_color %h", idx, color);
        mismatches++;
        return;
      end
      w = expected_writes.pop_front();
      if (idx !== w.pix_idx) begin
        $error("pixel_index expected %0d actual %0d", w.pix_idx, idx);
        mismatches++;
      end
      if (color !== w.pix_color) begin
        $error("pixel_color expected %h actual %h", w.pix_color, color);
        mismatches++;
      end
      if (last !== w.last_of_byte) begin
        $error("last_of_byte expected %b actual %b", w.last_of_byte, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [7:0]            in_font_byte = '0;
  logic                  in_glyph_start = 1'b0;
  logic [COORD_W-1:0]    in_start_x = '0;
  logic [COORD_W-1:0]    in_start_y = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [PIX_IDX_W-1:0]  out_pixel_index;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_last_of_byte;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_write_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pushed_bytes;

  glyph_bitmap_pixel_expander DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_font_byte     (in_font_byte),
    .in_glyph_start   (in_glyph_start),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_color  (out_pixel_color),
    .out_last_of_byte (out_last_of_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pixel write sink with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty)
        board.check_write(out_pixel_index, out_pixel_color, out_last_of_byte);
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_font_byte(input logic [7:0] fb, input logic st,
                                input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_font_byte   <= fb;
    in_glyph_start <= st;
    in_start_x     <= sx;
    in_start_y     <= sy;
    do @(posedge clk); while (in_full);
    pushed_bytes++;
    void'(board.note_byte(fb, st, sx, sy));
  endtask

  // leaves cfg_valid high; the caller drops it after the last register
  task automatic drive_register(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    board.apply_register(r, d);
  endtask

  task automatic write_config(input logic [SIZE_W-1:0] size, input logic ovl,
                              input logic [COLOR_W-1:0] txt, input logic [COLOR_W-1:0] bk,
                              input logic land);
    logic [CFG_DATA_W-1:0] d;
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // bytes with no pixels may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    // upper data bits are don't-care for the narrow registers
    d = CFG_DATA_W'($urandom);
    d[SIZE_W-1:0] = size;
    drive_register(CFG_FONT_SIZE, d);
    d = CFG_DATA_W'($urandom);
    d[0] = ovl;
    drive_register(CFG_OVERLAY_MODE, d);
    drive_register(CFG_TEXT_COLOR, txt);
    drive_register(CFG_BACK_COLOR, bk);
    d = CFG_DATA_W'($urandom);
    d[0] = land;
    drive_register(CFG_LANDSCAPE, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    push_font_byte(8'hA5, 1'b0, 10'h3FF, 10'h3FF);   // no glyph active yet
    push_font_byte(8'hFF, 1'b1, 10'd0, 10'd0);
    push_font_byte(8'h00, 1'b0, 10'h155, 10'h2AA);
    push_font_byte(8'hA5, 1'b0, 10'h2AA, 10'h155);
    push_font_byte(8'h5A, 1'b0, 10'h000, 10'h3FF);
    push_font_byte(8'hFF, 1'b1, 10'd5, 10'd476);     // runs into the bottom edge
    push_font_byte(8'hFF, 1'b0, 10'd0, 10'd0);
    push_font_byte(8'hFF, 1'b1, 10'd799, 10'd0);     // last column before right edge
    push_font_byte(8'h81, 1'b0, 10'd0, 10'd0);
    push_font_byte(8'hFF, 1'b0, 10'd0, 10'd0);
    push_font_byte(8'hFF, 1'b1, 10'h3FF, 10'h3FF);   // entirely off the panel
    write_config(6'd12, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
    push_font_byte(8'hF0, 1'b1, 10'd0, 10'd0);
    push_font_byte(8'hC3, 1'b0, 10'd0, 10'd0);
    push_font_byte(8'hFF, 1'b1, 10'd479, 10'd799);   // portrait corner pixel
    push_font_byte(8'hFF, 1'b1, 10'd480, 10'd10);    // portrait x past panel height
    push_font_byte(8'h80, 1'b1, 10'd100, 10'd0);
    write_config(6'd32, 1'b0, 16'h0000, 16'hFFFF, 1'b0);
    push_font_byte(8'hFF, 1'b0, 10'd0, 10'd0);
    push_font_byte(8'h00, 1'b0, 10'd0, 10'd0);
    // shrink the size mid-column: column closes after one bit
    write_config(6'd12, 1'b0, 16'h1234, 16'hEDCB, 1'b1);
    push_font_byte(8'hFF, 1'b0, 10'd0, 10'd0);
  endtask

  task automatic run_phase(input int quota);
    int unsigned        total;
    int unsigned        n;
    int unsigned        kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    pushed_bytes = 0;
    // stray bytes first: continue a cut-off glyph under the new setting or get ignored
    repeat ($urandom_range(0, 2))
      push_font_byte(8'($urandom), 1'b0, COORD_W'($urandom), COORD_W'($urandom));
    while (pushed_bytes < quota) begin
      total = board.glyph_bytes(board.cfg.font_size);
      if (total == 0) total = 1;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: begin
          sx = COORD_W'($urandom);
          sy = COORD_W'($urandom);
        end
        1: begin
          sx = COORD_W'($urandom_range(0, 799));
          sy = COORD_W'($urandom_range(0, 479));
        end
        2: begin
          sx = COORD_W'($urandom_range(770, 800));
          sy = COORD_W'($urandom_range(440, 480));
        end
        default: begin
          sx = COORD_W'($urandom_range(440, 480));
          sy = COORD_W'($urandom_range(0, 799));
        end
      endcase
      if (kind <= 6) n = total;
      else if (kind == 7) n = $urandom_range(1, total);
      else if (kind == 8) n = total + $urandom_range(1, 3);
      else n = $urandom_range(1, 2);
      for (int j = 0; j < n && pushed_bytes < quota; j++) begin
        if (j == 0 && kind != 9)
          push_font_byte(8'($urandom), 1'b1, sx, sy);
        else
          push_font_byte(8'($urandom), 1'b0, COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 50;
    run_directed();
    write_config(6'd16, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
    run_phase(40);
    write_config(6'd12, 1'b1, 16'($urandom), 16'($urandom), 1'b0);
    run_phase(40);
    write_config(6'd24, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
    run_phase(52);

    send_idle_pct = 50;
    recv_idle_pct = 9;
    write_config(6'd32, 1'b1, 16'($urandom), 16'($urandom), 1'b1);
    run_phase(70);
    write_config(6'd0, 1'b0, 16'($urandom), 16'($urandom), 1'b1);   // unsupported size
    run_phase(8);
    write_config(6'd32, 1'b0, 16'($urandom), 16'($urandom), 1'b0);
    run_phase(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(6'd12, 1'b0, 16'($urandom), 16'($urandom), 1'b1);
    run_phase(40);
    write_config(6'd16, 1'b1, 16'($urandom), 16'($urandom), 1'b0);
    run_phase(40);
    write_config(6'd24, 1'b1, 16'($urandom), 16'($urandom), 1'b1);
    run_phase(52);

    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
